// ===== hdl/apt_pkg.sv =====
// Package with shared constants, types and saturation helpers for the affine point transform.
package apt_pkg;

    localparam int unsigned CoordW = 32;
    localparam int unsigned FracW = 16;
    localparam int unsigned ProdW = 64;
    localparam int unsigned SumW = 68;
    localparam int unsigned QuotW = 50;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgDataW = 64;

    localparam logic [CfgIdxW-1:0] RegRow0Lo = 3'd0;
    localparam logic [CfgIdxW-1:0] RegRow0Hi = 3'd1;
    localparam logic [CfgIdxW-1:0] RegRow1Lo = 3'd2;
    localparam logic [CfgIdxW-1:0] RegRow1Hi = 3'd3;
    localparam logic [CfgIdxW-1:0] RegRow2Lo = 3'd4;
    localparam logic [CfgIdxW-1:0] RegRow2Hi = 3'd5;
    localparam logic [CfgIdxW-1:0] RegRow3Lo = 3'd6;
    localparam logic [CfgIdxW-1:0] RegRow3Hi = 3'd7;

    localparam logic [CfgDataW-1:0] LoOne = 64'h0000_0000_0001_0000;
    localparam logic [CfgDataW-1:0] HiOne = 64'h0001_0000_0000_0000;
    localparam logic signed [CoordW-1:0] QOne = 32'sh0001_0000;
    localparam logic signed [CoordW-1:0] MaxCoord = 32'sh7FFF_FFFF;
    localparam logic signed [CoordW-1:0] MinCoord = -32'sh7FFF_FFFF - 32'sh1;

    localparam logic CmdPoint = 1'b0;
    localparam logic CmdDirection = 1'b1;

    typedef logic signed [CoordW-1:0] coord_t;
    typedef logic signed [SumW-1:0] sum_t;
    typedef logic signed [QuotW-1:0] quot_t;

    // Clip a wide signed value to a Q16.16 coordinate.
    function automatic coord_t sat_coord(input sum_t v);
        coord_t r;
        if (v > sum_t'(MaxCoord)) begin
            r = MaxCoord;
        end
        else if (v < sum_t'(MinCoord)) begin
            r = MinCoord;
        end
        else begin
            r = v[CoordW-1:0];
        end
        return r;
    endfunction

    function automatic logic is_clipped(input sum_t v);
        return (v > sum_t'(MaxCoord)) || (v < sum_t'(MinCoord));
    endfunction

endpackage

// ===== hdl/apt_divider.sv =====
// Pipelined restoring divider: one quotient bit per stage, truncating toward zero.
module apt_divider
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  apt_pkg::sum_t             dividend,
    input  apt_pkg::coord_t           divisor,
    output logic                      out_valid,
    output logic [apt_pkg::QuotW-1:0] quotient_mag,
    output logic                      quotient_neg
);

    localparam int unsigned QW = apt_pkg::QuotW;
    localparam int unsigned DW = apt_pkg::CoordW;
    localparam int unsigned RW = DW + 1;

    logic [QW:0]    valid_reg;
    logic [QW-1:0]  num_reg [QW+1];
    logic [RW-1:0]  rem_reg [QW+1];
    logic [DW-1:0]  den_reg [QW+1];
    logic           neg_reg [QW+1];

    logic [QW-1:0]  num_abs;
    logic [DW-1:0]  den_abs;
    apt_pkg::sum_t  dividend_abs;

    always_comb
    begin
        dividend_abs = dividend[apt_pkg::SumW-1] ? -dividend : dividend;
        num_abs = dividend_abs[QW-1:0];
        den_abs = divisor[DW-1] ? DW'(-divisor) : divisor;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= '0;
        end
        else begin
            valid_reg <= {valid_reg[QW-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg[0] <= num_abs;
        rem_reg[0] <= '0;
        den_reg[0] <= den_abs;
        neg_reg[0] <= dividend[apt_pkg::SumW-1] ^ divisor[DW-1];
    end

    for (genvar s = 0; s < QW; s++) begin : g_step
        logic [RW-1:0] trial;
        logic [RW-1:0] diff;
        always_comb
        begin
            trial = {rem_reg[s][RW-2:0], num_reg[s][QW-1]};
            diff = trial - {1'b0, den_reg[s]};
        end
        always_ff @(posedge clk)
        begin
            if (!diff[RW-1]) begin
                rem_reg[s+1] <= diff;
                num_reg[s+1] <= {num_reg[s][QW-2:0], 1'b1};
            end
            else begin
                rem_reg[s+1] <= trial;
                num_reg[s+1] <= {num_reg[s][QW-2:0], 1'b0};
            end
            den_reg[s+1] <= den_reg[s];
            neg_reg[s+1] <= neg_reg[s];
        end
    end

    assign out_valid = valid_reg[QW];
    assign quotient_mag = num_reg[QW];
    assign quotient_neg = neg_reg[QW];

endmodule

// ===== hdl/affine_point_transform.sv =====
// Top level: 4x4 matrix vertex transform with perspective divide for points, Q16.16.
// Points and directions pass through the same pipeline registers and divider stages.
// Throughput: one vertex per cycle; each of the 50 divider stages yields one quotient bit.
// The result strobe done is high for one cycle per vertex; the receiver cannot stall.
// Reset clears all valid bits and loads the identity matrix.
// All eight register indexes are in use; each write replaces one 64-bit half of a matrix row.
module affine_point_transform
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [apt_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [apt_pkg::CfgDataW-1:0]  cfg_data,
    input  logic                          start,
    output logic                          busy,
    input  logic                          cmd,
    input  logic signed [31:0]            in_x,
    input  logic signed [31:0]            in_y,
    input  logic signed [31:0]            in_z,
    output logic                          done,
    output logic signed [31:0]            out_x,
    output logic signed [31:0]            out_y,
    output logic signed [31:0]            out_z,
    output logic                          saturated
);

    localparam int unsigned QW = apt_pkg::QuotW;
    localparam int unsigned SW = apt_pkg::SumW;
    localparam int unsigned DivLat = QW + 1;

    logic [apt_pkg::CfgDataW-1:0] row_reg [8];
    apt_pkg::coord_t m [4][4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            row_reg[apt_pkg::RegRow0Lo] <= apt_pkg::LoOne;
            row_reg[apt_pkg::RegRow0Hi] <= '0;
            row_reg[apt_pkg::RegRow1Lo] <= apt_pkg::HiOne;
            row_reg[apt_pkg::RegRow1Hi] <= '0;
            row_reg[apt_pkg::RegRow2Lo] <= '0;
            row_reg[apt_pkg::RegRow2Hi] <= apt_pkg::LoOne;
            row_reg[apt_pkg::RegRow3Lo] <= '0;
            row_reg[apt_pkg::RegRow3Hi] <= apt_pkg::HiOne;
        end
        else if (cfg_we) begin
            row_reg[cfg_index] <= cfg_data;
        end
    end

    for (genvar r = 0; r < 4; r++) begin : g_row
        for (genvar c = 0; c < 4; c++) begin : g_col
            assign m[r][c] = row_reg[2*r + c/2][32*(c%2) +: 32];
        end
    end

    assign busy = 1'b0;

    // Stage 1: register inputs.
    logic            s1_valid_reg;
    logic            s1_point_reg;
    apt_pkg::coord_t s1_v_reg [3];

    // Stage 2: twelve products.
    logic              s2_valid_reg;
    logic              s2_point_reg;
    logic signed [63:0] s2_p_reg [3][4];

    // Stage 3: rounded sums.
    logic            s3_valid_reg;
    logic            s3_point_reg;
    apt_pkg::sum_t   s3_sum_reg [4];

    // Stage 4: saturated coordinates and divide decision.
    logic            s4_valid_reg;
    logic            s4_div_reg;
    logic            s4_flag_reg;
    apt_pkg::coord_t s4_r_reg [3];
    apt_pkg::coord_t s4_w_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else begin
            s1_valid_reg <= start;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_point_reg <= (cmd == apt_pkg::CmdPoint);
        s1_v_reg[0] <= in_x;
        s1_v_reg[1] <= in_y;
        s1_v_reg[2] <= in_z;
        s2_point_reg <= s1_point_reg;
        s3_point_reg <= s2_point_reg;
    end

    for (genvar r = 0; r < 3; r++) begin : g_mul_r
        for (genvar c = 0; c < 4; c++) begin : g_mul_c
            always_ff @(posedge clk)
            begin
                s2_p_reg[r][c] <= s1_v_reg[r] * m[r][c];
            end
        end
    end

    for (genvar c = 0; c < 4; c++) begin : g_sum
        apt_pkg::sum_t sum_next;
        always_comb
        begin
            sum_next = SW'(s2_p_reg[0][c]) + SW'(s2_p_reg[1][c]) + SW'(s2_p_reg[2][c])
                + (s2_point_reg ? (SW'(m[3][c]) <<< apt_pkg::FracW) : '0)
                + SW'(64'sh8000);
        end
        always_ff @(posedge clk)
        begin
            s3_sum_reg[c] <= sum_next >>> apt_pkg::FracW;
        end
    end

    apt_pkg::coord_t w_sat;
    logic            flag_next;

    always_comb
    begin
        w_sat = apt_pkg::sat_coord(s3_sum_reg[3]);
        flag_next = apt_pkg::is_clipped(s3_sum_reg[0])
            || apt_pkg::is_clipped(s3_sum_reg[1])
            || apt_pkg::is_clipped(s3_sum_reg[2])
            || (s3_point_reg && apt_pkg::is_clipped(s3_sum_reg[3]));
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++) begin
            s4_r_reg[i] <= apt_pkg::sat_coord(s3_sum_reg[i]);
        end
        s4_w_reg <= w_sat;
        s4_div_reg <= s3_point_reg && (w_sat != apt_pkg::QOne) && (w_sat != '0);
        s4_flag_reg <= flag_next;
    end

    // Three dividers in parallel; a unit divisor passes the value through unchanged.
    logic              dv_valid [3];
    logic [QW-1:0]     dv_mag [3];
    logic              dv_neg [3];
    apt_pkg::coord_t   dv_den;

    assign dv_den = s4_div_reg ? s4_w_reg : apt_pkg::QOne;

    for (genvar i = 0; i < 3; i++) begin : g_div
        apt_divider u_div
        (
            .clk          (clk),
            .rst_n        (rst_n),
            .in_valid     (s4_valid_reg),
            .dividend     (SW'(s4_r_reg[i]) <<< apt_pkg::FracW),
            .divisor      (dv_den),
            .out_valid    (dv_valid[i]),
            .quotient_mag (dv_mag[i]),
            .quotient_neg (dv_neg[i])
        );
    end

    logic [DivLat-1:0] flag_line_reg;

    always_ff @(posedge clk)
    begin
        flag_line_reg <= {flag_line_reg[DivLat-2:0], s4_flag_reg};
    end

    // Output stage.
    logic            done_reg;
    apt_pkg::coord_t out_reg [3];
    logic            sat_reg;
    apt_pkg::sum_t   q [3];
    logic            qflag;

    always_comb
    begin
        qflag = 1'b0;
        for (int i = 0; i < 3; i++) begin
            q[i] = dv_neg[i] ? -SW'(dv_mag[i]) : SW'(dv_mag[i]);
            qflag = qflag | apt_pkg::is_clipped(q[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            done_reg <= 1'b0;
        end
        else begin
            done_reg <= dv_valid[0];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++) begin
            out_reg[i] <= apt_pkg::sat_coord(q[i]);
        end
        sat_reg <= flag_line_reg[DivLat-1] | qflag;
    end

    assign done = done_reg;
    assign out_x = out_reg[0];
    assign out_y = out_reg[1];
    assign out_z = out_reg[2];
    assign saturated = sat_reg;

    // The three dividers run in lockstep.
    assert property (@(posedge clk) disable iff (!rst_n)
        (dv_valid[0] == dv_valid[1]) && (dv_valid[1] == dv_valid[2]))
        else $error("divider lanes out of step");

    // Every valid stage-4 item is followed by a result beat on done.
    assert property (@(posedge clk) disable iff (!rst_n)
        s4_valid_reg |-> ##(DivLat + 1) done)
        else $error("result beat missing");

    // No divide is ever set up for a direction item.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid_reg && !s3_point_reg) |=> !s4_div_reg)
        else $error("divide for a direction item");

endmodule
